// ===== rtl/core/sgtl_pkg.sv =====
// Shared constants, register codes and the power-of-two table for the torque limit block.
package sgtl_pkg;

    // Interpolation table size for 2^(-i/N)
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES);
    localparam int EXP_N_W = $clog2(EXP_TABLE_ENTRIES + 1);

    localparam int EXP_Y_W = 37;   // e^-y argument, Q5.32 (larger arguments are killed)
    localparam int EXP_V_W = 31;   // e^-y result, Q.30, at most 1.0

    localparam longint unsigned DEG_PER_RAD_Q16 = 64'd3754936;
    localparam longint unsigned LOG2E_Q24 = 64'h1715476;
    localparam longint unsigned LN2_Q32 = 64'hB17217F8;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMOID_SLOPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAUSS_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPTIMAL_ANGLE = 3'd4;

    localparam int GS_DIV_STEPS = 27;   // Gaussian distance quotient bits, Q3.24
    localparam int SG_DIV_STEPS = 31;   // sigmoid quotient bits, Q.30 up to 1.0
    localparam int STAGES = 44;         // input capture through output register

    typedef logic [EXP_V_W-1:0] pow2_tab_t [0:EXP_TABLE_ENTRIES];

    // floor(num / den) by shift and subtract, used while building the table
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(-i/N) in Q.30 from a 25 term Taylor series of e^-x in Q.32
    function automatic pow2_tab_t build_pow2_tab();
        pow2_tab_t tab;
        longint unsigned x;
        longint unsigned term;
        longint unsigned usum;
        longint sum;
        for (int i = 0; i <= EXP_TABLE_ENTRIES; i++)
        begin
            x = (longint'(i) * LN2_Q32) / EXP_TABLE_ENTRIES;
            term = 64'd1 << 32;
            sum = longint'(term);
            for (int n = 1; n <= 24; n++)
            begin
                term = udiv64((term * x) >> 32, 64'(n));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            usum = longint'(unsigned'(sum)) + 64'd2;
            tab[i] = EXP_V_W'(usum >> 2);
        end
        return tab;
    endfunction

    localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

// ===== rtl/core/sgtl_if.sv =====
// Handshake channels of the torque limit block: joint samples, results, register writes.
interface sgtl_sample_if;
    import sgtl_pkg::*;
    logic valid;
    logic ready;
    logic signed [15:0] joint_angle;
    logic signed [19:0] joint_speed;
    modport source (output valid, output joint_angle, output joint_speed, input ready);
    modport sink (input valid, input joint_angle, input joint_speed, output ready);
endinterface

interface sgtl_result_if;
    import sgtl_pkg::*;
    logic valid;
    logic ready;
    logic signed [31:0] max_torque;
    logic saturated;
    modport source (output valid, output max_torque, output saturated, input ready);
    modport sink (input valid, input max_torque, input saturated, output ready);
endinterface

interface sgtl_cfg_if;
    import sgtl_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sgtl_expn.sv =====
// Five stage e^-y unit: log2e scaling, table interpolation of 2^-frac, shift by the integer part.
module sgtl_expn (
    input  logic                          clk,
    input  logic                          en,
    input  logic [sgtl_pkg::EXP_Y_W-1:0]  y,
    input  logic                          kill,
    output logic [sgtl_pkg::EXP_V_W-1:0]  e
);
    import sgtl_pkg::*;

    localparam int PW = 32 + EXP_N_W;

    logic [61:0] z_prod;
    logic [37:0] z1_reg, z1_next;
    logic        kill1_reg;

    logic [PW-1:0]        p_full;
    logic [EXP_N_W-1:0]   p_idx;
    logic [EXP_IDX_W-1:0] i2_reg, i2_next;
    logic [31:0]          f2_reg;
    logic [4:0]           k2_reg;
    logic                 big2_reg, big2_next;

    logic [EXP_V_W-1:0] a3_reg, b3_reg;
    logic [31:0]        f3_reg;
    logic [4:0]         k3_reg;
    logic               big3_reg;
    logic [EXP_IDX_W:0] i_hi;

    logic [62:0]        d4_reg, d4_next;
    logic [EXP_V_W-1:0] a4_reg;
    logic [4:0]         k4_reg;
    logic               big4_reg;

    logic [EXP_V_W-1:0] v5, e_reg, e_next;

    // z = y * log2(e), Q6.32
    assign z_prod = 62'(y) * 62'(LOG2E_Q24);
    assign z1_next = z_prod[61:24];

    always_comb
    begin
        p_full = PW'(z1_reg[31:0]) * PW'(EXP_TABLE_ENTRIES);
        p_idx = p_full[PW-1:32];
        if (p_idx >= EXP_N_W'(EXP_TABLE_ENTRIES))
            i2_next = EXP_IDX_W'(EXP_TABLE_ENTRIES - 1);
        else
            i2_next = p_idx[EXP_IDX_W-1:0];
        // 2^-k vanishes in Q.30 once k reaches 31
        big2_next = kill1_reg || (z1_reg[37:32] >= 6'd31);
    end

    assign i_hi = {1'b0, i2_reg} + (EXP_IDX_W + 1)'(1);
    assign d4_next = 63'(a3_reg - b3_reg) * 63'(f3_reg);

    always_comb
    begin
        v5 = a4_reg - d4_reg[62:32];
        e_next = big4_reg ? '0 : (v5 >> k4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg <= z1_next;
            kill1_reg <= kill;
            i2_reg <= i2_next;
            f2_reg <= p_full[31:0];
            k2_reg <= z1_reg[36:32];
            big2_reg <= big2_next;
            a3_reg <= POW2_TAB[i2_reg];
            b3_reg <= POW2_TAB[i_hi];
            f3_reg <= f2_reg;
            k3_reg <= k2_reg;
            big3_reg <= big2_reg;
            d4_reg <= d4_next;
            a4_reg <= a3_reg;
            k4_reg <= k3_reg;
            big4_reg <= big3_reg;
            e_reg <= e_next;
        end
    end

    assign e = e_reg;

endmodule

// ===== rtl/core/sigmoid_gauss_torque_limit.sv =====
// Top level: pipelined sigmoid-scaled Gaussian maximum torque with saturation.
// One joint sample is taken per clock while the result side does not stall;
// a stall at the result freezes the whole pipeline, which then resumes
// without loss. The latency is set by the sigmoid path: three input stages,
// a five stage exponential unit, a restoring divider with one quotient bit
// per stage (32 stages for the 31 bit ratio) and four stages of multiply,
// offset, scale and clip. The Gaussian path (divider, squaring, second
// exponential unit) runs beside it and is delayed to match. Registers are
// written through the cfg channel, which is always ready; write them only
// while no sample is in flight.
module sigmoid_gauss_torque_limit (
    input logic         clk,
    input logic         rst_n,
    sgtl_sample_if.sink sample,
    sgtl_result_if.source result,
    sgtl_cfg_if.sink    cfg
);
    import sgtl_pkg::*;

    logic               en;
    logic [STAGES-1:0]  v_reg;

    logic signed [31:0] peak_gain_reg;
    logic signed [31:0] sigmoid_slope_reg;
    logic signed [31:0] peak_offset_reg;
    logic [30:0]        gauss_width_reg;
    logic signed [31:0] optimal_angle_reg;
    logic [30:0]        r_eff;

    // conversion and products
    logic signed [15:0] ang0_reg;
    logic signed [19:0] spd0_reg;
    logic signed [39:0] ang_prod;
    logic signed [43:0] spd_prod;
    logic signed [25:0] pos1_reg;
    logic signed [29:0] spdd1_reg;
    logic signed [61:0] x2_reg, x2_next;
    logic signed [32:0] dsig;
    logic [32:0]        diff2_reg, diff2_next;
    logic [61:0]        xmag;

    // Gaussian distance divider
    logic [30:0] grem_reg [0:GS_DIV_STEPS];
    logic [26:0] glo_reg  [0:GS_DIV_STEPS];
    logic [26:0] gq_reg   [0:GS_DIV_STEPS];
    logic        gfar_reg [0:GS_DIV_STEPS];
    logic [30:0] grem_next [1:GS_DIV_STEPS];
    logic        gge_next  [1:GS_DIV_STEPS];
    logic [31:0] gsh;
    logic [53:0] sq31_reg;
    logic        far31_reg;

    // sigmoid
    logic [EXP_V_W-1:0] t7, g36;
    logic [4:0]         neg_reg;
    logic [EXP_V_W-1:0] gd_reg [0:4];
    logic [31:0]        sden_reg [0:SG_DIV_STEPS];
    logic [31:0]        srem_reg [0:SG_DIV_STEPS];
    logic [30:0]        slo_reg  [0:SG_DIV_STEPS];
    logic [30:0]        sq_reg   [0:SG_DIV_STEPS];
    logic [31:0]        srem_next [1:SG_DIV_STEPS];
    logic               sge_next  [1:SG_DIV_STEPS];
    logic [32:0]        ssh;
    logic [60:0]        snum;

    logic signed [63:0] pp40_reg;
    logic signed [33:0] peak41_reg;
    logic signed [65:0] tp42_reg;
    logic signed [35:0] tq;
    logic signed [31:0] torque_reg, torque_next;
    logic               sat_reg, sat_next;

    assign en = !v_reg[STAGES-1] || result.ready;
    assign sample.ready = en;
    assign cfg.ready = 1'b1;
    assign result.valid = v_reg[STAGES-1];
    assign result.max_torque = torque_reg;
    assign result.saturated = sat_reg;

    assign r_eff = (gauss_width_reg == '0) ? 31'd1 : gauss_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], sample.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_gain_reg <= '0;
            sigmoid_slope_reg <= '0;
            peak_offset_reg <= '0;
            gauss_width_reg <= 31'd65536;
            optimal_angle_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_PEAK_GAIN:     peak_gain_reg <= cfg.data;
                REG_SIGMOID_SLOPE: sigmoid_slope_reg <= cfg.data;
                REG_PEAK_OFFSET:   peak_offset_reg <= cfg.data;
                REG_GAUSS_WIDTH:   gauss_width_reg <= cfg.data[30:0];
                REG_OPTIMAL_ANGLE: optimal_angle_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // radians to degrees, rounded then floored: slicing a two's complement value floors it
    always_comb
    begin
        ang_prod = 40'(ang0_reg) * 40'sd3754936 + 40'sd2048;
        spd_prod = 44'(spd0_reg) * 44'sd3754936 + 44'sd2048;
        x2_next = 62'(sigmoid_slope_reg) * 62'(spdd1_reg);
        dsig = 33'(optimal_angle_reg) - 33'(pos1_reg);
        diff2_next = dsig[32] ? 33'(-dsig) : 33'(dsig);
        xmag = x2_reg[61] ? 62'(-x2_reg) : 62'(x2_reg);
    end

    always_comb
    begin
        for (int j = 1; j <= GS_DIV_STEPS; j++)
        begin
            gsh = {grem_reg[j-1], glo_reg[j-1][26]};
            gge_next[j] = gsh >= {1'b0, r_eff};
            grem_next[j] = gge_next[j] ? 31'(gsh - {1'b0, r_eff}) : gsh[30:0];
        end
        for (int j = 1; j <= SG_DIV_STEPS; j++)
        begin
            ssh = {srem_reg[j-1], slo_reg[j-1][30]};
            sge_next[j] = ssh >= {1'b0, sden_reg[j-1]};
            srem_next[j] = sge_next[j] ? 32'(ssh - {1'b0, sden_reg[j-1]}) : ssh[31:0];
        end
        // numerator of 1/(1+e^-|x|) or e^-|x|/(1+e^-|x|)
        snum = neg_reg[4] ? (61'd1 << 60) : (61'(t7) << 30);
    end

    always_comb
    begin
        tq = tp42_reg[65:30];
        if (tq > 36'sd2147483647)
        begin
            torque_next = 32'sh7fffffff;
            sat_next = 1'b1;
        end
        else if (tq < -36'sd2147483648)
        begin
            torque_next = 32'sh80000000;
            sat_next = 1'b1;
        end
        else
        begin
            torque_next = tq[31:0];
            sat_next = 1'b0;
        end
    end

    sgtl_expn u_sig_exp (
        .clk  (clk),
        .en   (en),
        .y    (xmag[EXP_Y_W-1:0]),
        .kill (|xmag[61:EXP_Y_W]),
        .e    (t7)
    );

    sgtl_expn u_gauss_exp (
        .clk  (clk),
        .en   (en),
        .y    (sq31_reg[53:17]),
        .kill (far31_reg),
        .e    (g36)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang0_reg <= sample.joint_angle;
            spd0_reg <= sample.joint_speed;
            pos1_reg <= ang_prod[37:12];
            spdd1_reg <= spd_prod[41:12];
            x2_reg <= x2_next;
            diff2_reg <= diff2_next;

            // distance/width: the quotient only matters below 8.0
            grem_reg[0] <= {1'b0, diff2_reg[32:3]};
            glo_reg[0] <= {diff2_reg[2:0], 24'd0};
            gq_reg[0] <= '0;
            gfar_reg[0] <= {1'b0, diff2_reg[32:3]} >= r_eff;
            for (int j = 1; j <= GS_DIV_STEPS; j++)
            begin
                grem_reg[j] <= grem_next[j];
                glo_reg[j] <= {glo_reg[j-1][25:0], 1'b0};
                gq_reg[j] <= {gq_reg[j-1][25:0], gge_next[j]};
                gfar_reg[j] <= gfar_reg[j-1];
            end
            sq31_reg <= 54'(gq_reg[GS_DIV_STEPS]) * 54'(gq_reg[GS_DIV_STEPS]);
            far31_reg <= gfar_reg[GS_DIV_STEPS];

            gd_reg[0] <= g36;
            for (int j = 1; j <= 4; j++)
                gd_reg[j] <= gd_reg[j-1];

            neg_reg <= {neg_reg[3:0], x2_reg[61]};
            sden_reg[0] <= 32'd1073741824 + 32'(t7);
            srem_reg[0] <= {2'b00, snum[60:31]};
            slo_reg[0] <= snum[30:0];
            sq_reg[0] <= '0;
            for (int j = 1; j <= SG_DIV_STEPS; j++)
            begin
                sden_reg[j] <= sden_reg[j-1];
                srem_reg[j] <= srem_next[j];
                slo_reg[j] <= {slo_reg[j-1][29:0], 1'b0};
                sq_reg[j] <= {sq_reg[j-1][29:0], sge_next[j]};
            end

            pp40_reg <= 64'(peak_gain_reg) * 64'(signed'({1'b0, sq_reg[SG_DIV_STEPS]}));
            peak41_reg <= 34'(pp40_reg[63:30]) + 34'(peak_offset_reg);
            tp42_reg <= 66'(peak41_reg) * 66'(signed'({1'b0, gd_reg[4]}));
            torque_reg <= torque_next;
            sat_reg <= sat_next;
        end
    end

`ifndef SYNTH
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && !result.ready |=> v_reg[STAGES-1] && $stable(torque_reg))
        else $error("pending result dropped or changed");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && sat_reg |->
            (torque_reg == 32'sh7fffffff) || (torque_reg == 32'sh80000000))
        else $error("saturated result not at a bound");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the sigmoid-scaled Gaussian maximum torque block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgtl_pkg::*;

    localparam int TAB_N = 256;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] torque;
        logic        sat;
    } torque_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] value;
        logic [15:0] angle;
        logic [19:0] speed;
        bit          typed;
        torque_t     want;
    } row_t;

    logic clk;
    logic rst_n;

    sgtl_sample_if sample();
    sgtl_result_if result();
    sgtl_cfg_if    cfg();

    sigmoid_gauss_torque_limit dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample.sink),
        .result(result.source),
        .cfg(cfg.sink)
    );

    // predictor state
    longint unsigned pow2_q30 [0:TAB_N];
    longint gain_q, slope_q, offset_q, opt_q;
    longint unsigned width_q;

    torque_t torque_q [$];
    int errors;
    longint cycles;
    int idle_mode;       // 0: sender 35 / receiver 60, 1: swapped, 2: none
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void build_pow2();
        longint unsigned x, term;
        longint acc;
        for (int i = 0; i <= TAB_N; i++)
        begin
            x = (longint'(i) * LN2_Q32) / TAB_N;
            term = 64'd1 << 32;
            acc = longint'(term);
            for (int n = 1; n <= 24; n++)
            begin
                term = ((term * x) >> 32) / n;
                acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
            end
            pow2_q30[i] = (longint'(acc) + 2) >> 2;
        end
    endfunction

    function automatic longint unsigned absval(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint rad_to_deg(longint rad);
        return (rad * longint'(DEG_PER_RAD_Q16) + 2048) >>> 12;
    endfunction

    // e^-y, y in Q.32, result in Q.30
    function automatic longint unsigned exp_neg(longint unsigned y);
        longint unsigned z, u, p, i, f, a, b, v;
        longint unsigned k;
        if (y >= (64'd32 << 32))
            return 0;
        z = (y * LOG2E_Q24) >> 24;
        k = z >> 32;
        if (k >= 31)
            return 0;
        u = z & 64'hFFFF_FFFF;
        p = u * TAB_N;
        i = p >> 32;
        f = p & 64'hFFFF_FFFF;
        if (i >= TAB_N)
            i = TAB_N - 1;
        a = pow2_q30[i];
        b = pow2_q30[i + 1];
        v = a - (((a - b) * f) >> 32);
        return v >> k;
    endfunction

    function automatic torque_t predict_torque(logic [15:0] angle, logic [19:0] speed);
        longint pos, spd, x, peak, tq;
        longint unsigned t, s, r, w, g;
        torque_t res;
        pos = rad_to_deg(longint'($signed(angle)));
        spd = rad_to_deg(longint'($signed(speed)));
        x = slope_q * spd;
        t = exp_neg(absval(x));
        if (x >= 0)
            s = (t << 30) / ((64'd1 << 30) + t);
        else
            s = (64'd1 << 60) / ((64'd1 << 30) + t);
        peak = ((gain_q * longint'(s)) >>> 30) + offset_q;
        r = (width_q != 0) ? width_q : 1;
        w = (absval(opt_q - pos) << 24) / r;
        g = (w >= (64'd8 << 24)) ? 0 : exp_neg((w * w) >> 17);
        tq = (peak * longint'(g)) >>> 30;
        res.sat = 1'b0;
        if (tq > 64'sd2147483647)
        begin
            tq = 64'sd2147483647;
            res.sat = 1'b1;
        end
        else if (tq < -64'sd2147483648)
        begin
            tq = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.torque = tq[31:0];
        return res;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_PEAK_GAIN:     gain_q = longint'($signed(value));
            REG_SIGMOID_SLOPE: slope_q = longint'($signed(value));
            REG_PEAK_OFFSET:   offset_q = longint'($signed(value));
            REG_GAUSS_WIDTH:   width_q = {33'd0, value[30:0]};
            REG_OPTIMAL_ANGLE: opt_q = longint'($signed(value));
            default: ;
        endcase
    endfunction

    // scoreboard: predict on sample transaction, compare on result transaction
    always @(posedge clk)
    begin
        torque_t got, want;
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
                torque_q.push_back(predict_torque(sample.joint_angle, sample.joint_speed));
            if (result.valid && result.ready)
            begin
                got.torque = result.max_torque;
                got.sat = result.saturated;
                if (torque_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: torque %h sat %b", got.torque, got.sat);
                end
                else
                begin
                    want = torque_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: torque exp %h got %h, sat exp %b got %b",
                                     want.torque, got.torque, want.sat, got.sat);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sigmoid_gauss_torque_limit regression: fail");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (idle_mode == 0)
                result.ready <= ($urandom_range(0, 99) >= 60);
            else if (idle_mode == 1)
                result.ready <= ($urandom_range(0, 99) >= 35);
            else
                result.ready <= 1'b1;
        end
    end

    task automatic send_sample(logic [15:0] angle, logic [19:0] speed);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 35 : (idle_mode == 1) ? 60 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.joint_angle <= angle;
        sample.joint_speed <= speed;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (torque_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        apply_reg(idx, value);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_reg(logic [2:0] idx);
        int sel;
        sel = $urandom_range(0, 6);
        if (sel == 0)
            return 32'h7FFF_FFFF;
        if (sel == 1)
            return (idx == REG_GAUSS_WIDTH) ? 32'h0000_0001 : 32'h8000_0000;
        if (sel == 2)
            return $urandom;
        case (idx)
            REG_SIGMOID_SLOPE: return 32'($signed($urandom_range(0, 2047)) - 1024);
            REG_GAUSS_WIDTH:   return $urandom_range(1, 32'h0100_0000);
            REG_OPTIMAL_ANGLE: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            default:           return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
        endcase
    endfunction

    function automatic row_t item_row(logic [15:0] a, logic [19:0] s);
        row_t r;
        r = '{ROW_ITEM, 3'd0, 32'd0, a, s, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t typed_row(logic [15:0] a, logic [19:0] s, torque_t t);
        row_t r;
        r = '{ROW_ITEM, 3'd0, 32'd0, a, s, 1'b1, t};
        return r;
    endfunction

    function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] v);
        row_t r;
        r = '{ROW_CFG, idx, v, 16'd0, 20'd0, 1'b0, '0};
        return r;
    endfunction

    initial
    begin
        row_t rows [$];
        torque_t chk;
        logic [19:0] spd;
        errors = 0;
        cycles = 0;
        idle_mode = 2;
        hold_req = 1'b0;
        sample.valid = 1'b0;
        sample.joint_angle = '0;
        sample.joint_speed = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        build_pow2();
        gain_q = 0;
        slope_q = 0;
        offset_q = 0;
        width_q = 65536;
        opt_q = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset gain and offset are zero: torque 0
        rows.push_back(typed_row(16'h0000, 20'h00000, '{32'd0, 1'b0}));
        rows.push_back(typed_row(16'h7FFF, 20'h7FFFF, '{32'd0, 1'b0}));
        rows.push_back(typed_row(16'h8000, 20'h80000, '{32'd0, 1'b0}));
        // full positive, then full negative gain and offset at the optimum clip high, then low
        rows.push_back(cfg_row(REG_PEAK_GAIN, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(REG_PEAK_OFFSET, 32'h7FFF_FFFF));
        rows.push_back(typed_row(16'h0000, 20'h00000, '{32'h7FFF_FFFF, 1'b1}));
        rows.push_back(cfg_row(REG_PEAK_GAIN, 32'h8000_0000));
        rows.push_back(cfg_row(REG_PEAK_OFFSET, 32'h8000_0000));
        rows.push_back(typed_row(16'h0000, 20'h00000, '{32'h8000_0000, 1'b1}));
        // far from optimum: Gaussian vanishes
        rows.push_back(typed_row(16'h7FFF, 20'h00000, '{32'd0, 1'b0}));
        rows.push_back(cfg_row(REG_PEAK_GAIN, 32'h0001_0000));
        rows.push_back(cfg_row(REG_PEAK_OFFSET, 32'h0000_8000));
        rows.push_back(cfg_row(REG_SIGMOID_SLOPE, 32'h0000_0100));
        rows.push_back(cfg_row(REG_GAUSS_WIDTH, 32'h0050_0000));
        rows.push_back(cfg_row(REG_OPTIMAL_ANGLE, 32'h0014_0000));
        rows.push_back(item_row(16'h0100, 20'h00800));
        rows.push_back(item_row(16'hFF00, 20'hFF800));
        rows.push_back(item_row(16'h7FFF, 20'h7FFFF));
        rows.push_back(item_row(16'h8000, 20'h80000));
        // steep sigmoid in both directions
        rows.push_back(cfg_row(REG_SIGMOID_SLOPE, 32'h7FFF_FFFF));
        rows.push_back(item_row(16'h0150, 20'h7FFFF));
        rows.push_back(item_row(16'h0150, 20'h80000));
        // zero width is taken as the least positive width; then the widest width at extreme optimum angles
        rows.push_back(cfg_row(REG_GAUSS_WIDTH, 32'h0000_0000));
        rows.push_back(cfg_row(REG_SIGMOID_SLOPE, 32'h0000_0000));
        rows.push_back(cfg_row(REG_OPTIMAL_ANGLE, 32'h0000_0000));
        rows.push_back(item_row(16'h0000, 20'h00123));
        rows.push_back(item_row(16'h0001, 20'h00000));
        rows.push_back(cfg_row(REG_GAUSS_WIDTH, 32'hFFFF_FFFF));
        rows.push_back(cfg_row(REG_OPTIMAL_ANGLE, 32'h7FFF_FFFF));
        rows.push_back(item_row(16'h8000, 20'h00000));
        rows.push_back(cfg_row(REG_OPTIMAL_ANGLE, 32'h8000_0000));
        rows.push_back(item_row(16'h7FFF, 20'h00000));
        // out-of-range index is ignored
        rows.push_back(cfg_row(3'd7, 32'hDEAD_BEEF));
        rows.push_back(item_row(16'h1234, 20'h01234));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(rows[i].idx, rows[i].value);
            end
            else
            begin
                if (rows[i].typed)
                begin
                    chk = predict_torque(rows[i].angle, rows[i].speed);
                    if (chk !== rows[i].want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("row %0d: predictor %h/%b, table %h/%b", i,
                                     chk.torque, chk.sat, rows[i].want.torque,
                                     rows[i].want.sat);
                    end
                end
                send_sample(rows[i].angle, rows[i].speed);
            end
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            idle_mode = ph / 2;
            for (int r = 0; r <= 5; r++)
                write_reg(3'(r), pick_reg(3'(r)));
            if (ph == 0 || ph == 3)
                hold_req <= 1'b1;
            for (int n = 0; n < 255; n++)
            begin
                if ($urandom_range(0, 1))
                    spd = 20'($urandom);
                else
                    spd = 20'($signed($urandom_range(0, 16383)) - 8192);
                send_sample(16'($urandom), spd);
            end
        end

        wait_idle();
        if (errors == 0 && torque_q.size() == 0)
            $display("sigmoid_gauss_torque_limit regression: pass");
        else
            $display("sigmoid_gauss_torque_limit regression: fail");
        $finish;
    end
endmodule
